// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/ils_pkg.sv -----
`default_nettype none

package ils_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 9;
   localparam int POS_W    = 9;
   localparam int KIND_W   = 3;
   localparam int WORD_W   = 32;
   localparam int STAT_W   = 2;

   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic capture;
      logic read_pos;
      logic write_word;
      logic start_shift;
      logic shift_step;
      logic commit;
   } ils_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              ok;
      logic              shift_needed;
      logic              shift_last;
   } ils_stat_type;

endpackage

`default_nettype wire

// ----- sv/indexed_list_store_top.sv -----
// Indexed list store: ordered list of signed 32-bit words, up to 256 entries.
// req_ channel: kind (append, remove last, insert, erase, read, write),
// position and word. rsp_ channel: read_word (zero unless a good read),
// status (ok, index out of range, full, empty) and entries_used after it.
// One response per request, in order; a rejected request changes nothing.
// A request goes from idle through check to result, passing the shift state
// for an insert or erase that moves entries, and then the final state for an
// insert that moved entries; the response is registered. Entries are moved
// one at a time, as the entry memory has a single write port; the longest
// request is an insert at the front of a list of 255 entries.
// One request is worked at a time; req_ready is high only while idle, so a
// new request is not taken before the last one is committed.
// A finished response sits in an output register, so the next request is
// accepted while the receiver stalls; that request's response waits until
// the register is taken.
// Synchronous reset empties the list; entry contents are not cleared.
`default_nettype none
`include "assert_macros.svh"

module indexed_list_store_top import ils_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire [KIND_W-1:0]         req_kind,
   input  wire [POS_W-1:0]          req_position,
   input  wire signed [WORD_W-1:0]  req_word,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic signed [WORD_W-1:0] rsp_read_word,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]         rsp_entries_used
);

   ils_cmd_type  cmd;
   ils_stat_type stat;
   logic         rsp_full, rsp_empty, rsp_has_word;

   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ils_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_word         (req_word),
      .rsp_read_word    (rsp_read_word),
      .rsp_status       (rsp_status),
      .rsp_entries_used (rsp_entries_used)
   );

   assign rsp_full     = rsp_valid && (rsp_status == ST_FULL);
   assign rsp_empty    = rsp_valid && (rsp_status == ST_EMPTY);
   assign rsp_has_word = rsp_valid && (rsp_read_word != '0);

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_ALWAYS(a_count_bound, clock, reset, !rsp_valid || rsp_entries_used <= CNT_W'(CAPACITY))
   `ASSERT_ALWAYS(a_empty_status, clock, reset, !rsp_empty || rsp_entries_used == '0)
   `ASSERT_ALWAYS(a_full_status, clock, reset, !rsp_full || rsp_entries_used == CNT_W'(CAPACITY))
   `ASSERT_ALWAYS(a_read_ok, clock, reset, !rsp_has_word || rsp_status == ST_OK)

endmodule

`default_nettype wire

// ----- sv/ils_datapath.sv -----
`default_nettype none

module ils_datapath import ils_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   input  wire ils_cmd_type        cmd,
   output ils_stat_type            stat,
   input  wire [KIND_W-1:0]        req_kind,
   input  wire [POS_W-1:0]         req_position,
   input  wire signed [WORD_W-1:0] req_word,
   output logic signed [WORD_W-1:0] rsp_read_word,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [CNT_W-1:0]        rsp_entries_used
);

   logic [WORD_W-1:0] entry_mem_ff [CAPACITY];
   logic [WORD_W-1:0] rd_word_ff;

   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] word_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;

   logic [WORD_W-1:0] out_word_ff;
   logic [STAT_W-1:0] out_status_ff;
   logic [CNT_W-1:0]  out_count_ff;

   logic [STAT_W-1:0] status;
   logic [CNT_W-1:0]  count_m1;
   logic              is_insert;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   logic [WORD_W-1:0] mem_wd;

   assign count_m1  = count_ff - CNT_W'(1);
   assign is_insert = (kind_ff == KIND_INSERT);

   always_comb begin
      status = ST_OK;
      case (kind_ff)
         KIND_APPEND: begin
            if (count_ff >= CNT_W'(CAPACITY)) status = ST_FULL;
         end
         KIND_REMOVE: begin
            if (count_ff == '0) status = ST_EMPTY;
         end
         KIND_INSERT: begin
            // range is checked ahead of fullness
            if (pos_ff > count_ff) status = ST_RANGE;
            else if (count_ff >= CNT_W'(CAPACITY)) status = ST_FULL;
         end
         KIND_ERASE, KIND_READ, KIND_WRITE: begin
            if (pos_ff >= count_ff) status = ST_RANGE;
         end
         default: status = ST_OK;
      endcase
   end

   always_comb begin
      stat.kind = kind_ff;
      stat.ok   = (status == ST_OK);
      // insert moves entries pos..count-1; erase moves pos+1..count-1
      stat.shift_needed = is_insert ? (pos_ff < count_ff) : (pos_ff != count_m1);
      stat.shift_last   = is_insert ? (cursor_ff == pos_ff[IDX_W-1:0])
                                    : (cursor_ff == count_m1[IDX_W-1:0]);
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.start_shift) begin
         cursor_in = is_insert ? count_m1[IDX_W-1:0] : IDX_W'(pos_ff + POS_W'(1));
      end else if (cmd.shift_step) begin
         cursor_in = is_insert ? cursor_ff - IDX_W'(1) : cursor_ff + IDX_W'(1);
      end
   end

   // read one entry ahead, write the previous read one slot over
   always_comb begin
      mem_re = cmd.read_pos | cmd.start_shift | cmd.shift_step;
      mem_ra = cmd.read_pos ? pos_ff[IDX_W-1:0] : cursor_in;
      mem_we = cmd.write_word | cmd.shift_step;
      if (cmd.shift_step) begin
         mem_wa = is_insert ? cursor_ff + IDX_W'(1) : cursor_ff - IDX_W'(1);
         mem_wd = rd_word_ff;
      end else begin
         mem_wa = (kind_ff == KIND_APPEND) ? count_ff[IDX_W-1:0] : pos_ff[IDX_W-1:0];
         mem_wd = word_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (status == ST_OK) begin
         case (kind_ff)
            KIND_APPEND, KIND_INSERT: count_in = count_ff + CNT_W'(1);
            KIND_REMOVE, KIND_ERASE:  count_in = count_m1;
            default:                  count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) entry_mem_ff[mem_wa] <= mem_wd;
      if (mem_re) rd_word_ff <= entry_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         word_ff <= req_word;
      end
      cursor_ff <= cursor_in;
      if (cmd.commit) begin
         out_word_ff   <= (kind_ff == KIND_READ && status == ST_OK) ? rd_word_ff : '0;
         out_status_ff <= status;
         out_count_ff  <= count_in;
      end
   end

   assign rsp_read_word    = out_word_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_entries_used = out_count_ff;

endmodule

`default_nettype wire

// ----- sv/ils_ctrl.sv -----
`default_nettype none

module ils_ctrl import ils_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  wire ils_stat_type stat,
   output ils_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_FINAL  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.capture = req_valid && req_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_RESULT;
            if (stat.ok) begin
               case (stat.kind)
                  KIND_APPEND, KIND_WRITE: cmd.write_word = 1'b1;
                  KIND_READ:               cmd.read_pos   = 1'b1;
                  KIND_INSERT: begin
                     if (stat.shift_needed) begin
                        cmd.start_shift = 1'b1;
                        state_in        = S_SHIFT;
                     end else begin
                        cmd.write_word = 1'b1;
                     end
                  end
                  KIND_ERASE: begin
                     if (stat.shift_needed) begin
                        cmd.start_shift = 1'b1;
                        state_in        = S_SHIFT;
                     end
                  end
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_last) begin
               state_in = (stat.kind == KIND_INSERT) ? S_FINAL : S_RESULT;
            end
         end
         S_FINAL: begin
            cmd.write_word = 1'b1;
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- verif/ils_checker.sv -----
`timescale 1ns / 1ps

module ils_checker import ils_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [WORD_W-1:0] req_word,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [WORD_W-1:0] rsp_read_word,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic [CNT_W-1:0]         rsp_entries_used,
   output int                       fail_count,
   output int                       pending,
   output int                       rsp_checked,
   output int                       full_hits,
   output int                       empty_hits,
   output int                       range_hits,
   output int                       top_fill
);

   typedef struct packed {
      logic signed [WORD_W-1:0] read_word;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         used;
   } list_rsp_type;

   logic signed [WORD_W-1:0] list_words [CAPACITY];
   int                       list_len;
   list_rsp_type             awaited_rsp [$];

   // Updates the list copy and returns the response the block owes.
   function automatic list_rsp_type apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [WORD_W-1:0] word);
      list_rsp_type r;
      int           p;
      int           i;
      p = int'(pos);
      r.read_word = '0;
      r.status = ST_OK;
      case (kind)
         KIND_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_len] = word;
               list_len++;
            end
         end
         KIND_REMOVE: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               list_len--;
            end
         end
         KIND_INSERT: begin
            // index is checked before fullness
            if (p > list_len) begin
               r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = word;
               list_len++;
            end
         end
         KIND_ERASE: begin
            if (p >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               list_len--;
               for (i = p; i < list_len; i++) list_words[i] = list_words[i+1];
            end
         end
         KIND_READ: begin
            if (p >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.read_word = list_words[p];
            end
         end
         KIND_WRITE: begin
            if (p >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               list_words[p] = word;
            end
         end
         default: begin
         end
      endcase
      r.used = CNT_W'(list_len);
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      list_rsp_type want;
      list_rsp_type got;
      if (reset) begin
         list_len = 0;
         awaited_rsp.delete();
      end else begin
         // a response can never belong to a word accepted on the same edge
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_read_word, rsp_status, rsp_entries_used};
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response with none outstanding: word 0x%08h status %0d used %0d",
                           $realtime, got.read_word, got.status, got.used);
               end
            end else begin
               want = awaited_rsp.pop_front();
               rsp_checked++;
               if (got.read_word !== want.read_word) begin
                  note_mismatch("read_word", want.read_word, got.read_word);
               end
               if (got.status !== want.status) begin
                  note_mismatch("status", WORD_W'(want.status), WORD_W'(got.status));
               end
               if (got.used !== want.used) begin
                  note_mismatch("entries_used", WORD_W'(want.used), WORD_W'(got.used));
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_kind, req_position, req_word);
            awaited_rsp = {awaited_rsp, want};
            case (want.status)
               ST_FULL:  full_hits++;
               ST_EMPTY: empty_hits++;
               ST_RANGE: range_hits++;
               default: begin
               end
            endcase
            if (list_len > top_fill) top_fill = list_len;
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import ils_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SEGMENTS    = 15;
   localparam int SEG_WORDS   = 100;
   // kinds the block ignores
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_HOVER} drift_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic [KIND_W-1:0]        req_kind = KIND_APPEND;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [WORD_W-1:0] req_word = '0;
   logic                     rsp_ready = 1'b0;
   wire                      req_ready;
   wire                      rsp_valid;
   wire signed [WORD_W-1:0]  rsp_read_word;
   wire [STAT_W-1:0]         rsp_status;
   wire [CNT_W-1:0]          rsp_entries_used;

   logic quiet = 1'b0;
   int   rsp_hold;
   int   hold_draw;
   int   idle_cycles;
   int   fill_level;
   int   fail_count;
   int   pending;
   int   rsp_checked;
   int   full_hits;
   int   empty_hits;
   int   range_hits;
   int   top_fill;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_list_store_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_word    (rsp_read_word),
      .rsp_status       (rsp_status),
      .rsp_entries_used (rsp_entries_used)
   );

   ils_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_word    (rsp_read_word),
      .rsp_status       (rsp_status),
      .rsp_entries_used (rsp_entries_used),
      .fail_count       (fail_count),
      .pending          (pending),
      .rsp_checked      (rsp_checked),
      .full_hits        (full_hits),
      .empty_hits       (empty_hits),
      .range_hits       (range_hits),
      .top_fill         (top_fill)
   );

   // Receiver: after each taken word, draw a random hold; ready stays low until it counts down on cycles with valid.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         hold_draw = quiet ? 0 : $urandom_range(0, 3);
         rsp_hold <= hold_draw;
         rsp_ready <= (hold_draw == 0);
      end else if (rsp_hold > 0) begin
         if (rsp_valid) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ready <= (rsp_hold == 1);
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_word(input logic [KIND_W-1:0] kind, input int pos,
                            input logic signed [WORD_W-1:0] word);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_position <= POS_W'(pos);
      req_word <= word;
      do @(posedge clock); while (!req_ready);
      // rough fill tracking, only to steer the random mix
      case (kind)
         KIND_APPEND: if (fill_level < CAPACITY) fill_level++;
         KIND_REMOVE: if (fill_level > 0) fill_level--;
         KIND_INSERT: if (pos <= fill_level && fill_level < CAPACITY) fill_level++;
         KIND_ERASE:  if (pos < fill_level) fill_level--;
         default: begin
         end
      endcase
   endtask

   task automatic send_random_word(input drift_type mode, output bit counted);
      int                       roll;
      int                       grow_pct;
      int                       shrink_pct;
      logic [KIND_W-1:0]        kind;
      int                       pos;
      logic signed [WORD_W-1:0] word;
      case (mode)
         MODE_GROW: begin
            grow_pct = 70;
            shrink_pct = 10;
         end
         MODE_SHRINK: begin
            grow_pct = 10;
            shrink_pct = 70;
         end
         default: begin
            grow_pct = 35;
            shrink_pct = 35;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
         kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
      end else if (roll < grow_pct + shrink_pct) begin
         kind = $urandom_range(0, 1) ? KIND_REMOVE : KIND_ERASE;
      end else if (roll < 98) begin
         kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
      end else begin
         kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end
      if ($urandom_range(0, 99) < 15) begin
         pos = $urandom_range(0, (1 << POS_W) - 1);
      end else if (kind == KIND_INSERT) begin
         pos = $urandom_range(0, fill_level);
      end else if (fill_level == 0) begin
         pos = 0;
      end else begin
         pos = $urandom_range(0, fill_level - 1);
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: word = 32'h8000_0000;
            1: word = 32'h7fff_ffff;
            2: word = 32'h0000_0000;
            default: word = 32'hffff_ffff;
         endcase
      end else begin
         word = $urandom();
      end
      send_word(kind, pos, word);
      counted = (kind <= KIND_WRITE);
   endtask

   initial begin : stimulus
      int        seg;
      int        done;
      bit        counted;
      drift_type mode;
      fill_level = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty-store rejections
      send_word(KIND_REMOVE, 0, 0);
      send_word(KIND_ERASE, 0, 0);
      send_word(KIND_READ, 0, 0);
      send_word(KIND_WRITE, 0, 32'h1234_5678);
      send_word(KIND_INSERT, 1, 32'h0000_0001);
      // build a short list with extreme values
      send_word(KIND_INSERT, 0, 32'h8000_0000);
      send_word(KIND_APPEND, 0, 32'h7fff_ffff);
      send_word(KIND_APPEND, 0, 32'hffff_ffff);
      send_word(KIND_INSERT, 3, 32'h0000_0000);
      send_word(KIND_INSERT, 1, 32'h5555_5555);
      send_word(KIND_READ, 0, 0);
      send_word(KIND_READ, 4, 0);
      send_word(KIND_READ, 5, 0);
      send_word(KIND_WRITE, 4, 32'haaaa_aaaa);
      send_word(KIND_READ, 4, 0);
      send_word(KIND_ERASE, 0, 0);
      send_word(KIND_ERASE, 3, 0);
      send_word(KIND_SPARE_LO, (1 << POS_W) - 1, 32'hdead_beef);
      send_word(KIND_SPARE_HI, 0, 0);
      send_word(KIND_READ, (1 << POS_W) - 1, 0);
      send_word(KIND_ERASE, CAPACITY, 0);
      send_word(KIND_INSERT, (1 << POS_W) - 1, 32'h0f0f_0f0f);
      send_word(KIND_READ, 1, 0);

      // fill to capacity, sit there, drain to empty, then wander
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 5) mode = MODE_GROW;
         else if (seg == 5) mode = MODE_HOVER;
         else if (seg < 11) mode = MODE_SHRINK;
         else mode = drift_type'($urandom_range(0, 2));
         quiet <= (seg % 4 == 3);
         done = 0;
         while (done < SEG_WORDS) begin
            send_random_word(mode, counted);
            if (counted) done++;
         end
      end
      req_valid <= 1'b0;

      // let the checker log the last accepted word before polling
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Checked %0d responses; list reached %0d of %0d entries.",
               rsp_checked, top_fill, CAPACITY);
      $display("Rejected requests: %0d full, %0d empty, %0d index out of range.",
               full_hits, empty_hits, range_hits);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
